// ===== rtl/pdpc_pkg.sv =====
// Shared types, character constants and helpers for the path safety check chain.
`timescale 1ns / 1ps
`default_nettype none

package pdpc_pkg;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CTRL_LIM  = 8'h20;

	typedef enum logic [1:0] {
		ESC_NONE,
		ESC_HIGH,
		ESC_LOW
	} esc_t;

	// word passed from cell to cell, with the verdict riding on the last word
	typedef struct packed {
		logic       vld;
		logic       has;
		logic [7:0] c;
		logic       last;
		logic       decided;
		logic       safe;
		logic       pend;
	} tok_t;

	typedef struct packed {
		logic term;
		logic bad;
	} chk_t;

	function automatic logic is_sep(input logic [7:0] c);
		return (c == CH_SLASH) || (c == CH_BSLASH);
	endfunction

	// {valid, nibble}
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		priority if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, c[3:0]};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b1, 4'(c - 8'h37)};
		else
			r = '0;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/pdpc_check.sv =====
// Form check of one string stream: length, separators, colons, control bytes, dot-dot.
`timescale 1ns / 1ps
`default_nettype none

module pdpc_check import pdpc_pkg::*; #(
	parameter int MAX_LEN = 4096
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  tok_t      tin,
	output chk_t      chk
);

	localparam int POS_W = $clog2(MAX_LEN + 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);

	logic             term_q;
	logic             bad_q;
	logic [23:0]      win_q;
	logic [POS_W-1:0] pos_q;

	logic             take;
	logic             zero;
	logic             term1;
	logic             fin;
	logic             bad1;
	logic             bad2;
	logic [23:0]      win1;
	logic [POS_W-1:0] pos1;

	// last two bytes are ".." forming a whole component
	function automatic logic dotdot(input logic [POS_W-1:0] n, input logic [23:0] w);
		return (n >= POS_W'(2)) && (w[7:0] == CH_DOT) && (w[15:8] == CH_DOT) &&
			((n == POS_W'(2)) || is_sep(w[23:16]));
	endfunction

	always_comb begin
		take  = tin.vld && tin.has && !term_q;
		zero  = (tin.c == CH_NUL);
		pos1  = pos_q;
		win1  = win_q;
		bad1  = bad_q;
		if (take && !zero) begin
			if (pos_q >= POS_MAX || tin.c < CTRL_LIM || tin.c == CH_COLON)
				bad1 = 1'b1;
			if (pos_q == '0 && is_sep(tin.c))
				bad1 = 1'b1;
			if (is_sep(tin.c) && dotdot(pos_q, win_q))
				bad1 = 1'b1;
			win1 = {win_q[15:0], tin.c};
			if (pos_q < POS_MAX)
				pos1 = pos_q + POS_W'(1);
		end
		term1 = term_q || (take && zero);
		// end of string: a zero byte, or the last word on a live stream
		fin   = (take && zero) || (tin.vld && tin.last && !term1);
		bad2  = bad1 || (fin && ((pos1 == '0) || dotdot(pos1, win1)));
		chk.term = term_q;
		chk.bad  = bad2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q <= 1'b0;
			bad_q  <= 1'b0;
			win_q  <= '0;
			pos_q  <= '0;
		end else if (en && tin.vld) begin
			if (tin.last) begin
				term_q <= 1'b0;
				bad_q  <= 1'b0;
				win_q  <= '0;
				pos_q  <= '0;
			end else begin
				term_q <= term1;
				bad_q  <= bad2;
				win_q  <= win1;
				pos_q  <= pos1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pdpc_cell.sv =====
// One chain cell: form check plus one percent-decode pass, registered word out.
`timescale 1ns / 1ps
`default_nettype none

module pdpc_cell import pdpc_pkg::*; #(
	parameter int MAX_LEN = 4096
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  tok_t      tin,
	output tok_t      tout
);

	chk_t       chk;
	esc_t       phase_q;
	logic [3:0] hi_q;
	logic       chg_q;
	logic       fail_q;
	tok_t       tok_s1;

	esc_t       phase1;
	logic [3:0] hi1;
	logic       chg1;
	logic       fail1;
	logic       fwd;
	logic [7:0] fc;
	logic [4:0] hv;
	logic       term1;
	logic       dec;
	logic       sf;
	logic       pd;
	tok_t       nxt;

	pdpc_check #(.MAX_LEN(MAX_LEN)) u_check (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.tin    (tin),
		.chk    (chk)
	);

	always_comb begin
		phase1 = phase_q;
		hi1    = hi_q;
		chg1   = chg_q;
		fail1  = fail_q;
		fwd    = 1'b0;
		fc     = tin.c;
		hv     = hex_val(tin.c);
		if (tin.vld && tin.has && !chk.term) begin
			if (tin.c == CH_NUL) begin
				// terminator passes on even after a failed escape
				if (phase_q != ESC_NONE)
					fail1 = 1'b1;
				fwd = 1'b1;
			end else if (!fail_q) begin
				unique case (phase_q)
					ESC_NONE: begin
						if (tin.c == CH_PCT)
							phase1 = ESC_HIGH;
						else
							fwd = 1'b1;
					end
					ESC_HIGH: begin
						if (!hv[4]) begin
							fail1 = 1'b1;
						end else begin
							hi1    = hv[3:0];
							phase1 = ESC_LOW;
						end
					end
					ESC_LOW: begin
						if (!hv[4]) begin
							fail1 = 1'b1;
						end else begin
							phase1 = ESC_NONE;
							chg1   = 1'b1;
							fwd    = 1'b1;
							fc     = {hi_q, hv[3:0]};
						end
					end
					default: phase1 = ESC_NONE;
				endcase
			end
		end
		term1 = chk.term || (tin.vld && tin.has && tin.c == CH_NUL);
		// truncated escape at end of string
		if (tin.vld && tin.last && !term1 && phase1 != ESC_NONE)
			fail1 = 1'b1;

		// verdict: check k settles a pending pass, then decode k may open one
		dec = tin.decided;
		sf  = tin.safe;
		pd  = 1'b0;
		if (!dec) begin
			if (chk.bad) begin
				dec = 1'b1;
				sf  = 1'b0;
			end else if (tin.pend) begin
				dec = 1'b1;
				sf  = 1'b1;
			end
		end
		if (!dec) begin
			if (fail1) begin
				dec = 1'b1;
				sf  = 1'b0;
			end else if (!chg1) begin
				pd = 1'b1;
			end
		end

		nxt.vld     = tin.vld && (fwd || tin.last);
		nxt.has     = fwd;
		nxt.c       = fc;
		nxt.last    = tin.last;
		nxt.decided = dec;
		nxt.safe    = sf;
		nxt.pend    = pd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ESC_NONE;
			hi_q    <= '0;
			chg_q   <= 1'b0;
			fail_q  <= 1'b0;
			tok_s1  <= '0;
		end else if (en) begin
			tok_s1 <= nxt;
			if (tin.vld) begin
				if (tin.last) begin
					phase_q <= ESC_NONE;
					hi_q    <= '0;
					chg_q   <= 1'b0;
					fail_q  <= 1'b0;
				end else begin
					phase_q <= phase1;
					hi_q    <= hi1;
					chg_q   <= chg1;
					fail_q  <= fail1;
				end
			end
		end
	end

	assign tout = tok_s1;

endmodule

`default_nettype wire

// ===== rtl/percent_decoded_path_safety_check_core.sv =====
// Top level: chain of decode/check cells, a final check and the verdict register.
//
//   channel | signals                                   | direction
//   item    | item_valid, item_stall, char_byte,        | in
//           | has_char, is_last                         |
//   result  | result_valid, result_stall, path_safe     | out
//
// One byte per cycle while not stalled; each word moves one cell per cycle.
// The verdict for a path passes every cell register, then the verdict register.
// Reset clears every cell; no clearing pass. Cells clear themselves on a last word.
// A stalled verdict freezes the whole chain, and item_stall follows it at once.
`timescale 1ns / 1ps
`default_nettype none

module percent_decoded_path_safety_check_core import pdpc_pkg::*; #(
	parameter int MAX_LEN = 4096,
	parameter int PASSES  = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_stall,
	input  wire logic [7:0] char_byte,
	input  wire logic       has_char,
	input  wire logic       is_last,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic            path_safe
);

	tok_t tok [0:PASSES];
	chk_t fchk;
	logic en;
	logic verdict;
	logic result_valid_q;
	logic path_safe_q;

	assign en         = !(result_valid_q && result_stall);
	assign item_stall = !en;

	assign tok[0] = '{vld: item_valid, has: has_char, c: char_byte, last: is_last,
		decided: 1'b0, safe: 1'b0, pend: 1'b0};

	for (genvar k = 0; k < PASSES; k++) begin : g_cell
		pdpc_cell #(.MAX_LEN(MAX_LEN)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.tin    (tok[k]),
			.tout   (tok[k+1])
		);
	end

	// last check stage has no decode pass behind it
	pdpc_check #(.MAX_LEN(MAX_LEN)) u_check_last (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.tin    (tok[PASSES]),
		.chk    (fchk)
	);

	assign verdict = tok[PASSES].decided ? tok[PASSES].safe : (!fchk.bad && tok[PASSES].pend);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (en)
			result_valid_q <= tok[PASSES].vld && tok[PASSES].last;
	end

	always_ff @(posedge clk) begin
		if (en)
			path_safe_q <= verdict;
	end

	assign result_valid = result_valid_q;
	assign path_safe    = path_safe_q;

	a_last_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		(en && tok[PASSES].vld && tok[PASSES].last) |=> result_valid)
		else $error("last word at chain end gave no verdict");

	a_word_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(tok[PASSES].vld && tok[PASSES].last))
		else $error("verdict without a last word");

	a_pend_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(tok[PASSES].vld && tok[PASSES].decided && tok[PASSES].pend))
		else $error("verdict both decided and pending");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |-> item_stall)
		else $error("input taken while verdict held");

endmodule

`default_nettype wire
